/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL files.
// Depends on nothing; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock outside reset.
`define CHK_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("%m failed");
// Next-cycle implication outside reset.
`define CHK_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("%m failed");
`endif

/* rtl/gatl_pkg.sv */
// Package for the glyph atlas text layout block: types, codes and sizes.
// No dependencies.
package gatl_pkg;
  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = IDX_W + 1;
  localparam logic [15:0] CODE_FALLBACK = 16'd63;
  localparam logic [15:0] CODE_NEWLINE = 16'd10;

  localparam logic [2:0] REG_MAX_WIDTH = 3'd0;
  localparam logic [2:0] REG_LINE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_IMAGE_WIDTH = 3'd2;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd3;
  localparam logic [2:0] REG_GLYPH_COUNT = 3'd4;

  localparam logic [2:0] KIND_LOADED = 3'd0;
  localparam logic [2:0] KIND_QUAD = 3'd1;
  localparam logic [2:0] KIND_BREAK = 3'd2;
  localparam logic [2:0] KIND_MISSING = 3'd3;
  localparam logic [2:0] KIND_TOO_SMALL = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SRCH, ST_SREAD, ST_SCMP, ST_HREAD, ST_HCHK,
    ST_DECIDE, ST_DIV, ST_OUT
  } state_t;

  typedef struct packed {
    logic [11:0] ax;
    logic [11:0] ay;
    logic [7:0]  gw;
    logic [7:0]  gh;
    logic [7:0]  adv;
    logic [15:0] code;
  } entry_t;
endpackage

/* rtl/gatl_div.sv */
// Restoring divider, one quotient bit per cycle: (t << 16) / d, saturated.
// Depends on gatl_pkg, only for house consistency of types, and on assert_macros.svh.
module gatl_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [12:0] num,
  input  logic [12:0] den,
  output logic        done,
  output logic [15:0] quo
);
  import gatl_pkg::*;
  logic [28:0] dividend;
  logic [13:0] rem;
  logic [28:0] q;
  logic [4:0]  cnt;
  logic        busy;
  logic [12:0] d;
  logic [14:0] trial;

  assign trial = {rem, dividend[28]} - {2'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        dividend <= {num, 16'd0};
        d        <= (den == 13'd0) ? 13'd1 : den;
        rem      <= '0;
        q        <= '0;
        cnt      <= 5'd29;
      end else if (busy) begin
        if (!trial[14]) begin
          rem <= trial[13:0];
          q   <= {q[27:0], 1'b1};
        end else begin
          rem <= {rem[12:0], dividend[28]};
          q   <= {q[27:0], 1'b0};
        end
        dividend <= {dividend[27:0], 1'b0};
        cnt      <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = (q[28:16] != 13'd0) ? 16'hFFFF : q[15:0];
  `include "assert_macros.svh"
  `CHK_NEXT(a_div_done, clk, rst, busy && cnt == 5'd1 && !start, done)
endmodule

/* rtl/glyph_atlas_text_layout.sv */
// Glyph atlas text layout: loads glyph entries into a sorted table and turns
// characters into textured quads. A load beat writes its table slot on accept
// and goes straight to the output register. A render beat runs a lower-bound
// binary search over up to 256 entries: each probe steps through the SRCH,
// SREAD and SCMP states and the closing hit check through SRCH, HREAD and
// HCHK, repeated for '?' when missing. A quad then runs four divisions in turn
// on one shared restoring divider for the u/v coordinates, each of 29 quotient
// steps; non-quad results skip the divisions. The block accepts no beat while
// one is in work; the result sits in an output register.
// Depends on gatl_pkg, gatl_div and assert_macros.svh.
module glyph_atlas_text_layout (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata: entry_index[7:0], char_code[23:8], atlas_x[35:24], atlas_y[47:36],
  //        glyph_width[55:48], glyph_height[63:56], advance[71:64]
  input  logic [71:0] s_tdata,
  // tuser: mode[0], text_start[1]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata: pen_x, line_offset, quad_width, quad_height, u_left, u_right,
  //        v_top, v_bottom, base_vertex (lowest first)
  output logic [127:0] m_tdata,
  // tuser: kind[2:0]
  output logic [2:0]  m_tuser,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import gatl_pkg::*;

  // configuration
  logic [15:0] max_width;
  logic [7:0]  line_height;
  logic [12:0] image_width, image_height;
  logic [8:0]  glyph_count;

  // layout state
  logic [15:0] pen_position, line_position;
  logic [13:0] quad_total;

  state_t state, state_next;

  // glyph table
  entry_t mem [TABLE_DEPTH];
  entry_t rd;
  logic [IDX_W-1:0] rd_addr;

  // item registers
  logic [15:0] key;
  logic        fallback;
  logic [CNT_W-1:0] base, n, count;
  logic [CNT_W-1:0] half;
  entry_t hit;
  logic [1:0]  div_sel;
  logic        div_start, div_done;
  logic [12:0] div_num, div_den;
  logic [15:0] div_q;
  logic [15:0] u_l, u_r, v_t, v_b;
  logic [2:0]  kind;

  assign half  = n >> 1;
  assign count = (glyph_count > 9'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                 : CNT_W'(glyph_count);
  assign s_tready = (state == ST_IDLE) && !m_tvalid;
  // probe address is held through the read cycle so SCMP sees the probed slot
  assign rd_addr = (state == ST_SRCH || state == ST_SREAD) ? IDX_W'(base + half)
                                                           : IDX_W'(base);

  logic s_fire;
  assign s_fire = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (s_fire && !s_tuser[0])
      mem[s_tdata[7:0]] <= {s_tdata[35:24], s_tdata[47:36], s_tdata[55:48],
                            s_tdata[63:56], s_tdata[71:64], s_tdata[23:8]};
    rd <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_width    <= 16'd640;
      line_height  <= 8'd16;
      image_width  <= 13'd256;
      image_height <= 13'd256;
      glyph_count  <= 9'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_WIDTH:    max_width    <= cfg_data;
        REG_LINE_HEIGHT:  line_height  <= cfg_data[7:0];
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[12:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[12:0];
        REG_GLYPH_COUNT:  glyph_count  <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (s_fire) state_next = s_tuser[0] ? ST_SRCH : ST_OUT;
      ST_SRCH:   state_next = (n == '0) ? ST_HREAD : ST_SREAD;
      ST_SREAD:  state_next = ST_SCMP;
      ST_SCMP:   state_next = ST_SRCH;
      ST_HREAD:  state_next = ST_HCHK;
      ST_HCHK: begin
        if (base < count && rd.code == (fallback ? CODE_FALLBACK : key))
          state_next = ST_DECIDE;
        else if (!fallback) state_next = ST_SRCH;
        else state_next = ST_OUT;
      end
      ST_DECIDE: begin
        if (key == CODE_NEWLINE || {8'd0, hit.adv} >= max_width) state_next = ST_OUT;
        else state_next = ST_DIV;
      end
      ST_DIV:    if (div_done && div_sel == 2'd3) state_next = ST_OUT;
      ST_OUT:    if (m_tvalid && m_tready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // divider operand selection
  always_comb begin
    div_num = 13'd0;
    div_den = image_width;
    case (div_sel)
      2'd0: div_num = {1'b0, hit.ax};
      2'd1: div_num = {1'b0, hit.ax} + {5'd0, hit.gw};
      2'd2: begin div_num = {1'b0, hit.ay}; div_den = image_height; end
      2'd3: begin
        div_num = {1'b0, hit.ay} + {5'd0, hit.gh};
        div_den = image_height;
      end
      default: ;
    endcase
  end

  gatl_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_q)
  );

  logic [16:0] pen_sum;
  assign pen_sum = {1'b0, pen_position} + {9'd0, hit.adv};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_tvalid      <= 1'b0;
      pen_position  <= '0;
      line_position <= 16'd16;
      quad_total    <= '0;
      div_start     <= 1'b0;
    end else begin
      state     <= state_next;
      div_start <= 1'b0;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: if (s_fire) begin
          if (s_tuser[1]) begin
            pen_position  <= '0;
            line_position <= {8'd0, line_height};
            quad_total    <= '0;
          end
          key      <= s_tdata[23:8];
          fallback <= 1'b0;
          base     <= '0;
          n        <= count;
          kind     <= KIND_LOADED;
          u_l <= '0; u_r <= '0; v_t <= '0; v_b <= '0;
        end
        ST_SCMP: begin
          if (rd.code < (fallback ? CODE_FALLBACK : key)) begin
            base <= base + half + CNT_W'(1);
            n    <= n - half - CNT_W'(1);
          end else begin
            n <= half;
          end
        end
        ST_HCHK: begin
          if (base < count && rd.code == (fallback ? CODE_FALLBACK : key)) begin
            hit <= rd;
          end else if (!fallback) begin
            fallback <= 1'b1;
            base     <= '0;
            n        <= count;
          end else begin
            kind <= KIND_MISSING;
          end
        end
        ST_DECIDE: begin
          if (key == CODE_NEWLINE) begin
            if (pen_position == '0) kind <= KIND_TOO_SMALL;
            else begin
              kind          <= KIND_BREAK;
              pen_position  <= '0;
              line_position <= line_position + {8'd0, line_height};
            end
          end else if ({8'd0, hit.adv} >= max_width) begin
            kind <= KIND_TOO_SMALL;
          end else begin
            kind      <= KIND_QUAD;
            div_sel   <= 2'd0;
            div_start <= 1'b1;
            if (pen_sum >= {1'b0, max_width}) begin
              pen_position  <= '0;
              line_position <= line_position + {8'd0, line_height};
            end
          end
        end
        ST_DIV: if (div_done) begin
          case (div_sel)
            2'd0: u_l <= div_q;
            2'd1: u_r <= div_q;
            2'd2: v_t <= div_q;
            default: v_b <= div_q;
          endcase
          if (div_sel != 2'd3) begin
            div_sel   <= div_sel + 2'd1;
            div_start <= 1'b1;
          end
        end
        default: ;
      endcase
      if (state != ST_OUT && state_next == ST_OUT) m_tvalid <= 1'b1;
      if (state == ST_OUT && state_next == ST_IDLE && kind == KIND_QUAD) begin
        pen_position <= pen_position + {8'd0, hit.adv};
        quad_total   <= quad_total + 14'd1;
      end
    end
  end

  // result packing; quad counters advance when the beat leaves
  logic is_load, is_quad;
  assign is_load = (kind == KIND_LOADED);
  assign is_quad = (kind == KIND_QUAD);
  assign m_tuser = kind;
  assign m_tdata = {
    is_load ? 16'd0 : {quad_total, 2'b00},
    v_b, v_t, u_r, u_l,
    is_quad ? hit.gh : 8'd0,
    is_quad ? hit.gw : 8'd0,
    is_load ? 16'd0 : line_position,
    is_load ? 16'd0 : pen_position
  };

  `include "assert_macros.svh"
  `CHK_IMPL(a_ready_idle, clk, rst, s_tready, state == ST_IDLE && !m_tvalid)
  `CHK_IMPL(a_valid_out, clk, rst, m_tvalid, state == ST_OUT)
  `CHK_NEXT(a_done_leave, clk, rst, m_tvalid && m_tready, !m_tvalid)
  `CHK_IMPL(a_search_bound, clk, rst, state == ST_SCMP, base + n <= count)
endmodule

/* bench/tb.sv */
// Self-checking bench for glyph_atlas_text_layout: glyph table loads, lookups, wraps, quads.
// A scoreboard class predicts every result beat. Plain tasks drive the stream and config ports.
// Depends on gatl_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb;
  import gatl_pkg::*;

  localparam int LIMIT_CYCLES = 3000000;

  // One input beat, unpacked.
  typedef struct {
    bit          mode;
    logic [7:0]  slot;
    logic [15:0] code;
    logic [11:0] ax;
    logic [11:0] ay;
    logic [7:0]  gw;
    logic [7:0]  gh;
    logic [7:0]  adv;
    bit          start;
  } text_item_t;

  // One result beat, unpacked.
  typedef struct {
    logic [2:0]  kind;
    logic [15:0] pen;
    logic [15:0] line;
    logic [7:0]  qw;
    logic [7:0]  qh;
    logic [15:0] ul;
    logic [15:0] ur;
    logic [15:0] vt;
    logic [15:0] vb;
    logic [15:0] bv;
  } quad_beat_t;

  // Layout predictor plus the queue of quads and status beats still owed by the block.
  class layout_scoreboard;
    logic [15:0] g_code[TABLE_DEPTH];
    logic [11:0] g_ax[TABLE_DEPTH];
    logic [11:0] g_ay[TABLE_DEPTH];
    logic [7:0]  g_w[TABLE_DEPTH];
    logic [7:0]  g_h[TABLE_DEPTH];
    logic [7:0]  g_adv[TABLE_DEPTH];
    logic [15:0] max_w;
    logic [7:0]  line_h;
    logic [12:0] img_w;
    logic [12:0] img_h;
    logic [8:0]  n_glyphs;
    logic [15:0] pen;
    logic [15:0] line;
    logic [13:0] quads;
    quad_beat_t  owed[$];
    int          mismatches;

    function new();
      max_w = 640;
      line_h = 16;
      img_w = 256;
      img_h = 256;
      n_glyphs = 0;
      pen = 0;
      line = 16;
      quads = 0;
      mismatches = 0;
      foreach (g_code[i]) begin
        g_code[i] = 0; g_ax[i] = 0; g_ay[i] = 0; g_w[i] = 0; g_h[i] = 0; g_adv[i] = 0;
      end
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        REG_MAX_WIDTH:    max_w = val;
        REG_LINE_HEIGHT:  line_h = val[7:0];
        REG_IMAGE_WIDTH:  img_w = val[12:0];
        REG_IMAGE_HEIGHT: img_h = val[12:0];
        REG_GLYPH_COUNT:  n_glyphs = val[8:0];
        default: ;
      endcase
    endfunction

    // Lower-bound search over the sorted prefix; returns the slot or -1.
    function int find_glyph(logic [15:0] key);
      int cnt, lo, n, half;
      cnt = (n_glyphs < TABLE_DEPTH) ? n_glyphs : TABLE_DEPTH;
      lo = 0;
      n = cnt;
      while (n > 0) begin
        half = n / 2;
        if (g_code[lo + half] < key) begin
          lo = lo + half + 1;
          n = n - half - 1;
        end else begin
          n = half;
        end
      end
      if (lo < cnt && g_code[lo] == key) return lo;
      return -1;
    endfunction

    // floor(t * 2^16 / size), saturated; zero size counts as one
    function logic [15:0] to_unorm16(int unsigned t, int unsigned size);
      longint unsigned q;
      q = (longint'(t) << 16) / ((size == 0) ? 1 : size);
      return (q > 65535) ? 16'hFFFF : q[15:0];
    endfunction

    function void note_input(text_item_t it);
      quad_beat_t r;
      int s;
      r = '{default: 0};
      if (it.start) begin
        pen = 0;
        line = line_h;
        quads = 0;
      end
      if (!it.mode) begin
        g_code[it.slot] = it.code; g_ax[it.slot] = it.ax; g_ay[it.slot] = it.ay;
        g_w[it.slot] = it.gw; g_h[it.slot] = it.gh; g_adv[it.slot] = it.adv;
        r.kind = KIND_LOADED;
        owed = {owed, r};
        return;
      end
      s = find_glyph(it.code);
      if (s < 0) s = find_glyph(CODE_FALLBACK);
      if (s < 0) begin
        r.kind = KIND_MISSING;
      end else if (it.code == CODE_NEWLINE) begin
        if (pen == 0) begin
          r.kind = KIND_TOO_SMALL;
        end else begin
          pen = 0;
          line = line + line_h;
          r.kind = KIND_BREAK;
        end
      end else if (g_adv[s] >= max_w) begin
        r.kind = KIND_TOO_SMALL;
      end else begin
        // wrap first, then place the glyph on the fresh line
        if (17'(pen) + g_adv[s] >= max_w) begin
          pen = 0;
          line = line + line_h;
        end
        r.kind = KIND_QUAD;
        r.pen = pen;
        r.line = line;
        r.qw = g_w[s];
        r.qh = g_h[s];
        r.ul = to_unorm16(g_ax[s], img_w);
        r.ur = to_unorm16(g_ax[s] + g_w[s], img_w);
        r.vt = to_unorm16(g_ay[s], img_h);
        r.vb = to_unorm16(g_ay[s] + g_h[s], img_h);
        r.bv = {quads, 2'b00};
        pen = pen + g_adv[s];
        quads = quads + 1;
        owed = {owed, r};
        return;
      end
      // status beats report the state after the item
      r.pen = pen;
      r.line = line;
      r.bv = {quads, 2'b00};
      owed = {owed, r};
    endfunction

    function void check_result(quad_beat_t got);
      quad_beat_t exp;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result beat kind %0d", got.kind);
        return;
      end
      exp = owed.pop_front();
      if (got.kind != exp.kind || got.pen != exp.pen || got.line != exp.line ||
          got.qw != exp.qw || got.qh != exp.qh || got.ul != exp.ul || got.ur != exp.ur ||
          got.vt != exp.vt || got.vb != exp.vb || got.bv != exp.bv) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: exp kind %0d pen %0d line %0d wh %0d/%0d uv %h %h %h %h bv %0d",
                   exp.kind, exp.pen, exp.line, exp.qw, exp.qh, exp.ul, exp.ur, exp.vt,
                   exp.vb, exp.bv);
          $display("       got kind %0d pen %0d line %0d wh %0d/%0d uv %h %h %h %h bv %0d",
                   got.kind, got.pen, got.line, got.qw, got.qh, got.ul, got.ur, got.vt,
                   got.vb, got.bv);
        end
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [71:0]  s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [127:0] m_tdata;
  logic [2:0]   m_tuser;
  logic         cfg_we = 0;
  logic [2:0]   cfg_index = '0;
  logic [15:0]  cfg_data = '0;

  layout_scoreboard sb = new();
  int  n_items = 0;
  int  burst_left = 0;
  bit  no_gaps = 0;
  bit  hold_req = 0;   // sender asks the receiver for one long hold-off
  int  cycles = 0;

  glyph_atlas_text_layout DUT (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: checks every accepted beat; the stall pattern switches among four random phases.
  int  rx_phase = 0;
  int  hold_left = 0;
  bit  hold_done = 0;
  always @(posedge clk) begin
    quad_beat_t got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        // tdata: pen_x, line_offset, quad_width, quad_height, u_left, u_right,
        //        v_top, v_bottom, base_vertex from bit 0 up
        got.kind = m_tuser;
        got.pen  = m_tdata[15:0];
        got.line = m_tdata[31:16];
        got.qw   = m_tdata[39:32];
        got.qh   = m_tdata[47:40];
        got.ul   = m_tdata[63:48];
        got.ur   = m_tdata[79:64];
        got.vt   = m_tdata[95:80];
        got.vb   = m_tdata[111:96];
        got.bv   = m_tdata[127:112];
        sb.check_result(got);
      end
      if (cycles % 300 == 0) rx_phase = $urandom_range(0, 3);
      if (hold_req && !hold_done && hold_left == 0) hold_left = 4000;
      if (hold_left > 0) begin
        hold_left--;
        if (hold_left == 0) hold_done = 1;
        m_tready <= 0;
      end else begin
        case (rx_phase)
          0: m_tready <= 1;
          1: m_tready <= ($urandom_range(0, 1) == 1);
          2: m_tready <= ($urandom_range(0, 7) != 0);
          default: m_tready <= ($urandom_range(0, 5) == 0);
        endcase
      end
    end
  end

  // Offer one beat and wait for it to be taken; valid stays high for the next caller.
  task automatic send_item(text_item_t it);
    if (!no_gaps) begin
      if (burst_left == 0) begin
        s_tvalid <= 0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = $urandom_range(1, 10);
      end
      burst_left--;
    end
    s_tvalid <= 1;
    s_tdata  <= {it.adv, it.gh, it.gw, it.ay, it.ax, it.code, it.slot};
    s_tuser  <= {it.start, it.mode};
    do @(posedge clk); while (!s_tready);
    sb.note_input(it);
    n_items++;
  endtask

  // Pause the sender until every owed beat has come back, then let the block settle.
  task automatic drain();
    s_tvalid <= 0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Only called while the block is idle; cfg_we is lowered again after each write.
  task automatic cfg_write(logic [2:0] idx, logic [15:0] val);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  function automatic text_item_t glyph_load(int slot, logic [15:0] code, logic [11:0] ax,
                                            logic [11:0] ay, logic [7:0] gw, logic [7:0] gh,
                                            logic [7:0] adv, bit start);
    text_item_t it;
    it = '{mode: 0, slot: slot, code: code, ax: ax, ay: ay, gw: gw, gh: gh, adv: adv,
           start: start};
    return it;
  endfunction

  // Render beats carry random junk in the load-only fields.
  function automatic text_item_t char_render(logic [15:0] code, bit start);
    text_item_t it;
    it = '{mode: 1, slot: $urandom, code: code, ax: $urandom, ay: $urandom, gw: $urandom,
           gh: $urandom, adv: $urandom, start: start};
    return it;
  endfunction

  function automatic logic [7:0] rand_adv(int mw);
    if ($urandom_range(0, 19) == 0) return $urandom_range(0, 255);
    return $urandom_range(0, (mw > 60) ? 60 : mw);
  endfunction

  // Fill slots 0..n-1 with strictly increasing codes; newline and '?' at random.
  task automatic load_sorted(int n, int mw);
    logic [15:0] c;
    int k;
    k = 0;
    if (n > 2 && $urandom_range(0, 1)) begin
      send_item(glyph_load(k, CODE_NEWLINE, $urandom, $urandom, $urandom, $urandom,
                           rand_adv(mw), 0));
      k++;
    end
    if (n > 2 && $urandom_range(0, 3) != 0) begin
      send_item(glyph_load(k, CODE_FALLBACK, $urandom, $urandom, $urandom, $urandom,
                           rand_adv(mw), 0));
      k++;
    end
    c = 64;
    for (; k < n; k++) begin
      c = c + $urandom_range(1, 250);
      if (k == n - 1 && $urandom_range(0, 2) == 0) c = 16'hFFFF;
      send_item(glyph_load(k, c, $urandom, $urandom, $urandom, $urandom, rand_adv(mw),
                           $urandom_range(0, 9) == 0));
    end
  endtask

  initial begin
    int n, mw, pick, slot;
    text_item_t it;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: empty table first, then a small sorted table with field extremes.
    no_gaps = 1;
    send_item(char_render(16'h0041, 1));                      // nothing loaded: missing
    send_item(glyph_load(0, 16'h0000, 0, 0, 0, 0, 0, 0));
    send_item(glyph_load(1, CODE_NEWLINE, 1, 2, 3, 4, 5, 1));
    send_item(glyph_load(2, CODE_FALLBACK, 4095, 4095, 255, 255, 9, 0));
    send_item(glyph_load(3, 16'h0041, 100, 50, 8, 16, 200, 0));
    send_item(glyph_load(4, 16'h0042, 4095, 0, 255, 0, 255, 0));
    send_item(glyph_load(5, 16'h03E8, 0, 4095, 0, 255, 30, 0));
    send_item(glyph_load(6, 16'h9C40, 2048, 1024, 128, 64, 7, 0));
    send_item(glyph_load(255, 16'hFFFF, 4095, 4095, 255, 255, 255, 1));
    drain();
    cfg_write(REG_GLYPH_COUNT, 7);
    no_gaps = 0;
    send_item(char_render(CODE_NEWLINE, 1));                  // line feed at pen zero
    send_item(char_render(16'h0041, 0));
    send_item(char_render(CODE_NEWLINE, 0));                  // real line break
    send_item(char_render(16'h0005, 0));                      // falls back to '?'
    send_item(char_render(16'h0000, 0));
    send_item(char_render(16'h9C40, 0));
    send_item(char_render(16'h0041, 0));
    send_item(char_render(16'h0041, 0));
    send_item(char_render(16'h0041, 0));
    send_item(char_render(16'h0041, 0));                      // wraps at 640
    send_item(char_render(16'h0042, 0));
    drain();
    cfg_write(REG_MAX_WIDTH, 200);                            // 'A' and 'B' too wide
    cfg_write(REG_GLYPH_COUNT, 2);                            // no '?' visible
    send_item(char_render(16'h0041, 1));                      // missing, no fallback
    drain();
    cfg_write(REG_GLYPH_COUNT, 7);
    send_item(char_render(16'h0042, 0));                      // advance alone too wide
    send_item(char_render(16'h03E8, 0));
    drain();

    // Random phases: fresh sorted table and config, then text.
    for (int ph = 0; n_items < 1700; ph++) begin
      case ($urandom_range(0, 4))
        0: mw = 1;
        1: mw = 65535;
        2: mw = $urandom_range(1, 300);
        default: mw = $urandom_range(200, 1200);
      endcase
      n = (ph == 3) ? TABLE_DEPTH : $urandom_range(1, 24);
      if (ph == 5) n = 1;
      load_sorted(n, mw);
      drain();
      cfg_write(REG_MAX_WIDTH, mw);
      case ($urandom_range(0, 3))
        0: cfg_write(REG_LINE_HEIGHT, 1);
        1: cfg_write(REG_LINE_HEIGHT, 255);
        default: cfg_write(REG_LINE_HEIGHT, $urandom_range(1, 255));
      endcase
      cfg_write(REG_IMAGE_WIDTH, ($urandom_range(0, 3) == 0) ? 4096 :
                                 ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 4096));
      cfg_write(REG_IMAGE_HEIGHT, ($urandom_range(0, 3) == 0) ? 4096 :
                                  ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 4096));
      cfg_write(REG_GLYPH_COUNT, ($urandom_range(0, 9) == 0) ? 0 : n);
      no_gaps = ($urandom_range(0, 3) == 0);
      if (ph == 2) hold_req = 1;                              // receiver sits out a long stretch
      for (int k = 0; k < 150; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
          // noise: rewrite a live slot, which may unsort the table
          slot = $urandom_range(0, n - 1);
          it = glyph_load(slot, $urandom, $urandom, $urandom, $urandom, $urandom,
                          rand_adv(mw), $urandom_range(0, 1));
        end else if (pick < 60) begin
          it = char_render(sb.g_code[$urandom_range(0, n - 1)], 0);
        end else if (pick < 72) begin
          it = char_render(CODE_NEWLINE, 0);
        end else if (pick < 80) begin
          it = char_render(CODE_FALLBACK, 0);
        end else begin
          it = char_render($urandom, 0);
        end
        if ($urandom_range(0, 29) == 0) it.start = 1;
        send_item(it);
      end
      drain();
    end

    drain();
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
